### rtl/core/maple_frame_tx_rx_codec_defines.svh
// assertion macros used by the checker file
`ifndef MAPLE_FRAME_TX_RX_CODEC_DEFINES_SVH
`define MAPLE_FRAME_TX_RX_CODEC_DEFINES_SVH

// same-cycle implication
`define MFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mfc_pkg.sv
package mfc_pkg;

	localparam logic [7:0] MaxPayloadWords = 8'd255;
	localparam int unsigned MaxResults = 3;

	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_TX_DATA  = 3'd1;
	localparam logic [2:0] KIND_TX_CRC   = 3'd2;
	localparam logic [2:0] KIND_RX_DATA  = 3'd3;
	localparam logic [2:0] KIND_RX_CHECK = 3'd4;

	typedef struct packed {
		logic        func;
		logic [31:0] data_word;
		logic [7:0]  payload_len;
	} item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  out_kind;
		logic        frame_ok;
		logic [8:0]  word_index;
		logic        last;
	} result_t;

	// up to three results caused by one input beat
	typedef struct packed {
		result_t [MaxResults-1:0] res;
		logic [1:0]               cnt;
	} bundle_t;

	function automatic logic [31:0] swap_bytes(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [7:0] byte_xor(input logic [31:0] w);
		return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
	endfunction

	function automatic logic [7:0] clamp_len(input logic [7:0] n);
		return (n > MaxPayloadWords) ? MaxPayloadWords : n;
	endfunction

	function automatic result_t make_result(input logic [31:0] word, input logic [2:0] kind,
			input logic ok, input logic [8:0] idx, input logic lst);
		result_t r;
		r.out_word   = word;
		r.out_kind   = kind;
		r.frame_ok   = ok;
		r.word_index = idx;
		r.last       = lst;
		return r;
	endfunction

endpackage

### rtl/core/mfc_ifs.sv
interface mfc_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] data_word;
	logic [7:0]  payload_len;

	modport source(output valid, func, data_word, payload_len, input ready);
	modport sink(input valid, func, data_word, payload_len, output ready);
endinterface

interface mfc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic [2:0]  out_kind;
	logic        frame_ok;
	logic [8:0]  word_index;
	logic        last;

	modport source(output valid, out_word, out_kind, frame_ok, word_index, last, input ready);
	modport sink(input valid, out_word, out_kind, frame_ok, word_index, last, output ready);
endinterface

### rtl/core/mfc_framer.sv
module mfc_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mfc_pkg::item_t   item,
	output mfc_pkg::bundle_t bundle
);

	logic [7:0] tx_crc_q, tx_len_q, rx_crc_q, rx_len_q;
	logic [8:0] tx_pos_q, rx_pos_q;
	logic       rx_nz_q;

	logic [7:0] tx_crc_d, tx_len_d, rx_crc_d, rx_len_d;
	logic [8:0] tx_pos_d, rx_pos_d;
	logic       rx_nz_d;

	logic [7:0]  bx;
	logic [31:0] sw;
	logic [7:0]  len_c;
	logic [8:0]  pos_nx;
	logic        ok;

	always_comb begin
		bx       = mfc_pkg::byte_xor(item.data_word);
		sw       = mfc_pkg::swap_bytes(item.data_word);
		tx_crc_d = tx_crc_q;
		tx_len_d = tx_len_q;
		tx_pos_d = tx_pos_q;
		rx_crc_d = rx_crc_q;
		rx_len_d = rx_len_q;
		rx_pos_d = rx_pos_q;
		rx_nz_d  = rx_nz_q;
		len_c    = '0;
		pos_nx   = '0;
		ok       = 1'b0;
		bundle   = '0;
		if (!item.func) begin
			if (tx_pos_q == 9'd0) begin
				len_c         = mfc_pkg::clamp_len(item.payload_len);
				tx_len_d      = len_c;
				tx_crc_d      = bx;
				// header is (len*4+5)*8 bits
				bundle.res[0] = mfc_pkg::make_result({19'd0, len_c, 5'd0} + 32'd40,
						mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0);
				bundle.res[1] = mfc_pkg::make_result(sw, mfc_pkg::KIND_TX_DATA, 1'b0,
						9'd0, 1'b0);
				bundle.cnt    = 2'd2;
				tx_pos_d      = 9'd1;
				if (len_c == 8'd0) begin
					bundle.res[2] = mfc_pkg::make_result({bx, 24'd0}, mfc_pkg::KIND_TX_CRC,
							1'b0, 9'd1, 1'b1);
					bundle.cnt    = 2'd3;
					tx_pos_d      = 9'd0;
					tx_crc_d      = 8'd0;
				end
			end else begin
				tx_crc_d      = tx_crc_q ^ bx;
				bundle.res[0] = mfc_pkg::make_result(sw, mfc_pkg::KIND_TX_DATA, 1'b0,
						tx_pos_q, 1'b0);
				bundle.cnt    = 2'd1;
				pos_nx        = tx_pos_q + 9'd1;
				tx_pos_d      = pos_nx;
				if (pos_nx > {1'b0, tx_len_q}) begin
					bundle.res[1] = mfc_pkg::make_result({tx_crc_q ^ bx, 24'd0},
							mfc_pkg::KIND_TX_CRC, 1'b0, {1'b0, tx_len_q} + 9'd1, 1'b1);
					bundle.cnt    = 2'd2;
					tx_pos_d      = 9'd0;
					tx_crc_d      = 8'd0;
				end
			end
		end else begin
			if (rx_pos_q == 9'd0) begin
				rx_len_d      = mfc_pkg::clamp_len(item.data_word[31:24]);
				rx_nz_d       = (item.data_word != 32'd0);
				rx_crc_d      = bx;
				bundle.res[0] = mfc_pkg::make_result(sw, mfc_pkg::KIND_RX_DATA, 1'b0,
						9'd0, 1'b0);
				bundle.cnt    = 2'd1;
				rx_pos_d      = 9'd1;
			end else if (rx_pos_q <= {1'b0, rx_len_q}) begin
				rx_crc_d      = rx_crc_q ^ bx;
				bundle.res[0] = mfc_pkg::make_result(sw, mfc_pkg::KIND_RX_DATA, 1'b0,
						rx_pos_q, 1'b0);
				bundle.cnt    = 2'd1;
				rx_pos_d      = rx_pos_q + 9'd1;
			end else begin
				// check word is compared whole against the zero-extended crc
				ok            = (item.data_word == {24'd0, rx_crc_q}) && rx_nz_q;
				bundle.res[0] = mfc_pkg::make_result(item.data_word, mfc_pkg::KIND_RX_CHECK,
						ok, {1'b0, rx_len_q} + 9'd1, 1'b1);
				bundle.cnt    = 2'd1;
				rx_pos_d      = 9'd0;
				rx_crc_d      = 8'd0;
				rx_nz_d       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_crc_q <= '0;
			tx_len_q <= '0;
			tx_pos_q <= '0;
			rx_crc_q <= '0;
			rx_len_q <= '0;
			rx_pos_q <= '0;
			rx_nz_q  <= 1'b0;
		end else if (accept) begin
			tx_crc_q <= tx_crc_d;
			tx_len_q <= tx_len_d;
			tx_pos_q <= tx_pos_d;
			rx_crc_q <= rx_crc_d;
			rx_len_q <= rx_len_d;
			rx_pos_q <= rx_pos_d;
			rx_nz_q  <= rx_nz_d;
		end
	end

endmodule

### rtl/core/mfc_serializer.sv
module mfc_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mfc_pkg::bundle_t bundle,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output mfc_pkg::result_t out_res
);

	mfc_pkg::result_t [mfc_pkg::MaxResults-1:0] res_s1;
	logic [1:0] cnt_s1;
	logic [1:0] ptr_q;
	logic       bvalid_q;
	logic       ovalid_q;
	mfc_pkg::result_t out_q;

	logic load_out, take, last_take;

	assign load_out  = !ovalid_q || out_ready;
	assign take      = bvalid_q && load_out;
	assign last_take = take && (ptr_q == cnt_s1 - 2'd1);
	// a new beat may enter as the held bundle hands over its final result
	assign in_ready  = !bvalid_q || last_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			ptr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (accept) begin
				bvalid_q <= 1'b1;
				ptr_q    <= '0;
			end else if (last_take) begin
				bvalid_q <= 1'b0;
			end else if (take) begin
				ptr_q <= ptr_q + 2'd1;
			end
			if (load_out) begin
				ovalid_q <= bvalid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= bundle.res;
			cnt_s1 <= bundle.cnt;
		end
		if (take) begin
			out_q <= res_s1[ptr_q];
		end
	end

	assign out_valid = ovalid_q;
	assign out_res   = out_q;

endmodule

### rtl/core/maple_frame_tx_rx_codec.sv
// pipeline: an accepted beat's results pass through the bundle register, then the output register
// throughput: one beat per cycle while the output is ready; results leave one per
//   cycle, so a first transmit word (2 or 3 results) or a transmit last word (2)
//   holds the input until its final result is taken into the single output register
// reset: arst_n clears transmit and receive frame state and empties the output
module maple_frame_tx_rx_codec (
	input logic         clk,
	input logic         arst_n,
	mfc_item_if.sink    item,
	mfc_result_if.source result
);

	mfc_pkg::item_t   item_s;
	mfc_pkg::bundle_t bundle;
	mfc_pkg::result_t res;
	logic             accept;
	logic             in_ready;

	assign item_s.func        = item.func;
	assign item_s.data_word   = item.data_word;
	assign item_s.payload_len = item.payload_len;
	assign item.ready         = in_ready;
	assign accept             = item.valid && in_ready;

	mfc_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item_s),
		.bundle (bundle)
	);

	mfc_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.bundle    (bundle),
		.in_ready  (in_ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (res)
	);

	assign result.out_word   = res.out_word;
	assign result.out_kind   = res.out_kind;
	assign result.frame_ok   = res.frame_ok;
	assign result.word_index = res.word_index;
	assign result.last       = res.last;

endmodule

### rtl/core/mfc_checker.sv
`include "maple_frame_tx_rx_codec_defines.svh"

module mfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  out_kind,
	input logic        frame_ok,
	input logic [8:0]  word_index,
	input logic        last
);

	`MFC_ASSERT_NEXT(a_valid_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`MFC_ASSERT_IMPLY(a_last_kind, clk, arst_n, res_valid, last == ((out_kind == mfc_pkg::KIND_TX_CRC) || (out_kind == mfc_pkg::KIND_RX_CHECK)), "last on wrong result kind")
	`MFC_ASSERT_IMPLY(a_ok_kind, clk, arst_n, res_valid && frame_ok, out_kind == mfc_pkg::KIND_RX_CHECK, "frame_ok outside a check result")
	`MFC_ASSERT_IMPLY(a_header_idx, clk, arst_n, res_valid && (out_kind == mfc_pkg::KIND_HEADER), word_index == 9'd0, "header not at frame start")

endmodule

bind maple_frame_tx_rx_codec mfc_checker u_mfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.out_kind   (result.out_kind),
	.frame_ok   (result.frame_ok),
	.word_index (result.word_index),
	.last       (result.last)
);

### tb/tb_maple_frame_tx_rx_codec.sv
`timescale 1ns / 1ps

module tb_maple_frame_tx_rx_codec;

	typedef struct {
		mfc_pkg::item_t         it;
		int                     n_typed;
		mfc_pkg::result_t [2:0] typed;
	} dir_row_t;

	logic clk;
	logic arst_n;

	mfc_item_if   item_ch();
	mfc_result_if res_ch();

	maple_frame_tx_rx_codec u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// predictor copy of the frame state
	logic [7:0] tx_sum;
	logic [8:0] tx_at;
	logic [7:0] tx_words;
	logic [7:0] rx_sum;
	logic [8:0] rx_at;
	logic [7:0] rx_words;
	logic       rx_live;

	mfc_pkg::result_t want_q[$];
	dir_row_t         dir_rows[$];
	int               err_cnt = 0;
	int               beat_cnt = 0;
	int unsigned      cyc_cnt = 0;
	int unsigned      stall_left = 0;

	function automatic logic [31:0] flip_bytes(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [7:0] fold_bytes(input logic [31:0] w);
		logic [7:0] acc;
		acc = '0;
		for (int b = 0; b < 4; b++)
			acc ^= w[8*b +: 8];
		return acc;
	endfunction

	function automatic logic [7:0] cap_len(input logic [7:0] n);
		return (n > mfc_pkg::MaxPayloadWords) ? mfc_pkg::MaxPayloadWords : n;
	endfunction

	function automatic mfc_pkg::result_t mk_res(input logic [31:0] word,
			input logic [2:0] kind, input logic ok, input logic [8:0] idx, input logic lst);
		mfc_pkg::result_t r;
		r.out_word   = word;
		r.out_kind   = kind;
		r.frame_ok   = ok;
		r.word_index = idx;
		r.last       = lst;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic f, input logic [31:0] w,
			input logic [7:0] len, input int n = 0, input mfc_pkg::result_t r0 = '0,
			input mfc_pkg::result_t r1 = '0, input mfc_pkg::result_t r2 = '0);
		dir_row_t d;
		d.it.func        = f;
		d.it.data_word   = w;
		d.it.payload_len = len;
		d.n_typed        = n;
		d.typed          = {r2, r1, r0};
		return d;
	endfunction

	task automatic predict_frame_out(input mfc_pkg::item_t it, output mfc_pkg::result_t r[3],
			output int n);
		logic [31:0] hdr;
		logic        ok;
		n = 0;
		if (!it.func) begin
			if (tx_at == 9'd0) begin
				tx_words = cap_len(it.payload_len);
				tx_sum   = fold_bytes(it.data_word);
				hdr      = ({24'd0, tx_words} * 32'd4 + 32'd5) * 32'd8;
				r[0]     = mk_res(hdr, mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0);
				r[1]     = mk_res(flip_bytes(it.data_word), mfc_pkg::KIND_TX_DATA, 1'b0,
					9'd0, 1'b0);
				n        = 2;
				tx_at    = 9'd1;
			end else begin
				tx_sum ^= fold_bytes(it.data_word);
				r[0]   = mk_res(flip_bytes(it.data_word), mfc_pkg::KIND_TX_DATA, 1'b0,
					tx_at, 1'b0);
				n      = 1;
				tx_at  = tx_at + 9'd1;
			end
			if (tx_at > {1'b0, tx_words}) begin
				r[n]   = mk_res({tx_sum, 24'd0}, mfc_pkg::KIND_TX_CRC, 1'b0,
					{1'b0, tx_words} + 9'd1, 1'b1);
				n++;
				tx_at  = 9'd0;
				tx_sum = 8'd0;
			end
		end else begin
			if (rx_at == 9'd0) begin
				rx_words = cap_len(it.data_word[31:24]);
				rx_live  = (it.data_word != 32'd0);
				rx_sum   = fold_bytes(it.data_word);
				r[0]     = mk_res(flip_bytes(it.data_word), mfc_pkg::KIND_RX_DATA, 1'b0,
					9'd0, 1'b0);
				rx_at    = 9'd1;
			end else if (rx_at <= {1'b0, rx_words}) begin
				rx_sum ^= fold_bytes(it.data_word);
				r[0]   = mk_res(flip_bytes(it.data_word), mfc_pkg::KIND_RX_DATA, 1'b0,
					rx_at, 1'b0);
				rx_at  = rx_at + 9'd1;
			end else begin
				// check word is compared whole, upper bits included
				ok      = (it.data_word == {24'd0, rx_sum}) && rx_live;
				r[0]    = mk_res(it.data_word, mfc_pkg::KIND_RX_CHECK, ok,
					{1'b0, rx_words} + 9'd1, 1'b1);
				rx_at   = 9'd0;
				rx_sum  = 8'd0;
				rx_live = 1'b0;
			end
			n = 1;
		end
	endtask

	function automatic logic [7:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 199);
		if (r < 140)
			return 8'($urandom_range(0, 4));
		else if (r < 180)
			return 8'($urandom_range(5, 16));
		else if (r < 196)
			return 8'($urandom_range(17, 60));
		else if (r < 199)
			return 8'($urandom_range(61, 254));
		return 8'd255;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		// every fourth stretch of beats runs back to back
		if (((beat_cnt / 40) % 4) == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly well-formed frame traffic; drain keeps to channels inside a frame
	task automatic pick_word(input bit drain, output mfc_pkg::item_t it);
		int unsigned r;
		logic        f;
		if (drain)
			f = (tx_at != 9'd0 && rx_at != 9'd0) ? 1'($urandom_range(0, 1)) : (rx_at != 9'd0);
		else
			f = 1'($urandom_range(0, 1));
		it.func        = f;
		it.data_word   = $urandom;
		it.payload_len = 8'($urandom);
		r = $urandom_range(0, 19);
		if (r == 0)
			it.data_word = 32'd0;
		else if (r == 1)
			it.data_word = '1;
		if (!f) begin
			if (tx_at == 9'd0)
				it.payload_len = pick_len();
		end else if (rx_at == 9'd0) begin
			if (it.data_word != 32'd0)
				it.data_word[31:24] = pick_len();
		end else if (rx_at > {1'b0, rx_words}) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				it.data_word = {24'd0, rx_sum};
			else if (r == 6)
				it.data_word[7:0] = rx_sum;
			else if (r == 7)
				it.data_word = {24'd0, rx_sum ^ (8'd1 << $urandom_range(0, 7))};
		end
	endtask

	task automatic send_word(input mfc_pkg::item_t it, input int gap, input int n_typed,
			input mfc_pkg::result_t [2:0] typed);
		mfc_pkg::result_t pr[3];
		int               pn;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.func        <= it.func;
		item_ch.data_word   <= it.data_word;
		item_ch.payload_len <= it.payload_len;
		do @(posedge clk); while (!item_ch.ready);
		predict_frame_out(it, pr, pn);
		beat_cnt++;
		if (n_typed > 0) begin
			for (int k = 0; k < n_typed; k++)
				want_q.push_back(typed[k]);
		end else begin
			for (int k = 0; k < pn; k++)
				want_q.push_back(pr[k]);
		end
	endtask

	task automatic hold_for_drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (want_q.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// output stalls: short and long, with stretches of steady ready
	always @(posedge clk) begin
		int unsigned r;
		cyc_cnt <= cyc_cnt + 1;
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (((cyc_cnt / 400) % 4) == 2) begin
			res_ch.ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				stall_left   <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		mfc_pkg::result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (want_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual word %h kind %0d",
					$time, res_ch.out_word, res_ch.out_kind);
				err_cnt++;
			end else begin
				want = want_q.pop_front();
				check_field("out_word", want.out_word, res_ch.out_word);
				check_field("out_kind", 32'(want.out_kind), 32'(res_ch.out_kind));
				check_field("frame_ok", 32'(want.frame_ok), 32'(res_ch.frame_ok));
				check_field("word_index", 32'(want.word_index), 32'(res_ch.word_index));
				check_field("last", 32'(want.last), 32'(res_ch.last));
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_maple_frame_tx_rx_codec: FAIL");
		$finish;
	end

	initial begin
		mfc_pkg::item_t it;
		tx_sum              = '0;
		tx_at               = '0;
		tx_words            = '0;
		rx_sum              = '0;
		rx_at               = '0;
		rx_words            = '0;
		rx_live             = 1'b0;
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.func        = 1'b0;
		item_ch.data_word   = '0;
		item_ch.payload_len = '0;
		res_ch.ready        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-length transmit frames: header, word and crc from one beat; then a one-word frame
		dir_rows.push_back(mk_row(1'b0, 32'h0000_0000, 8'd0, 3,
			mk_res(32'd40, mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0),
			mk_res(32'h0000_0000, mfc_pkg::KIND_TX_DATA, 1'b0, 9'd0, 1'b0),
			mk_res(32'h0000_0000, mfc_pkg::KIND_TX_CRC, 1'b0, 9'd1, 1'b1)));
		dir_rows.push_back(mk_row(1'b0, 32'hFFFF_FFFF, 8'd0, 3,
			mk_res(32'd40, mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0),
			mk_res(32'hFFFF_FFFF, mfc_pkg::KIND_TX_DATA, 1'b0, 9'd0, 1'b0),
			mk_res(32'h0000_0000, mfc_pkg::KIND_TX_CRC, 1'b0, 9'd1, 1'b1)));
		dir_rows.push_back(mk_row(1'b0, 32'h0102_0304, 8'd1, 2,
			mk_res(32'd72, mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0),
			mk_res(32'h0403_0201, mfc_pkg::KIND_TX_DATA, 1'b0, 9'd0, 1'b0)));
		// payload_len is ignored on a payload beat
		dir_rows.push_back(mk_row(1'b0, 32'hAABB_CCDD, 8'hFF, 2,
			mk_res(32'hDDCC_BBAA, mfc_pkg::KIND_TX_DATA, 1'b0, 9'd1, 1'b0),
			mk_res(32'h0400_0000, mfc_pkg::KIND_TX_CRC, 1'b0, 9'd2, 1'b1)));
		// zero frame word: crc matches but the frame is flagged bad
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0000, 8'hFF, 1,
			mk_res(32'h0000_0000, mfc_pkg::KIND_RX_DATA, 1'b0, 9'd0, 1'b0)));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0000, 8'h00, 1,
			mk_res(32'h0000_0000, mfc_pkg::KIND_RX_CHECK, 1'b0, 9'd1, 1'b1)));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0001, 8'd0, 1,
			mk_res(32'h0100_0000, mfc_pkg::KIND_RX_DATA, 1'b0, 9'd0, 1'b0)));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0001, 8'd0, 1,
			mk_res(32'h0000_0001, mfc_pkg::KIND_RX_CHECK, 1'b1, 9'd1, 1'b1)));
		// check word with upper bits set fails, and is passed through unswapped
		dir_rows.push_back(mk_row(1'b1, 32'h0000_00FF, 8'd0, 1,
			mk_res(32'hFF00_0000, mfc_pkg::KIND_RX_DATA, 1'b0, 9'd0, 1'b0)));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_01FF, 8'd0, 1,
			mk_res(32'h0000_01FF, mfc_pkg::KIND_RX_CHECK, 1'b0, 9'd1, 1'b1)));
		// interleaved transmit and receive frames
		dir_rows.push_back(mk_row(1'b1, 32'h0211_2233, 8'h55));
		dir_rows.push_back(mk_row(1'b0, 32'h8000_0000, 8'd2));
		dir_rows.push_back(mk_row(1'b1, 32'hFFFF_FFFF, 8'hAA));
		dir_rows.push_back(mk_row(1'b0, 32'h7FFF_FFFF, 8'h00));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0000, 8'h0F));
		dir_rows.push_back(mk_row(1'b0, 32'h0000_0001, 8'hF0));
		dir_rows.push_back(mk_row(1'b1, 32'h0000_0002, 8'h00));
		// longest transmit frame and a mid-length receive frame, finished by random beats
		dir_rows.push_back(mk_row(1'b0, 32'hDEAD_BEEF, 8'd255, 2,
			mk_res(32'h0000_2008, mfc_pkg::KIND_HEADER, 1'b0, 9'd0, 1'b0),
			mk_res(32'hEFBE_ADDE, mfc_pkg::KIND_TX_DATA, 1'b0, 9'd0, 1'b0)));
		dir_rows.push_back(mk_row(1'b1, 32'h3C00_0000, 8'h3C));

		foreach (dir_rows[i])
			send_word(dir_rows[i].it, pick_gap(), dir_rows[i].n_typed, dir_rows[i].typed);
		while (tx_at != 9'd0 || rx_at != 9'd0) begin
			pick_word(1'b1, it);
			send_word(it, pick_gap(), 0, '0);
		end
		hold_for_drain();

		for (int k = 0; k < 190; k++) begin
			if (k == 90)
				hold_for_drain();
			pick_word(1'b0, it);
			send_word(it, pick_gap(), 0, '0);
		end
		while (tx_at != 9'd0 || rx_at != 9'd0) begin
			pick_word(1'b1, it);
			send_word(it, pick_gap(), 0, '0);
		end
		item_ch.valid <= 1'b0;

		@(posedge clk);
		while (want_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_maple_frame_tx_rx_codec: PASS");
		else
			$display("tb_maple_frame_tx_rx_codec: FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mfc_pkg.sv
rtl/core/mfc_ifs.sv
rtl/core/mfc_framer.sv
rtl/core/mfc_serializer.sv
rtl/core/maple_frame_tx_rx_codec.sv
rtl/core/mfc_checker.sv
tb/tb_maple_frame_tx_rx_codec.sv
